// ----- sv/pcw_pkg.sv -----
`default_nettype none

package pcw_pkg;

  localparam int BP_DEPTH = 32;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 7;
  localparam int SEG_O_W = 5;
  localparam int NP_W    = 6;

  // APB register map
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic [0:0] REG_NUM_POINTS = 1'b0;
  localparam logic [NP_W-1:0] NUM_POINTS_RST = NP_W'(2);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_BP   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_COEF = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_EVAL = 2'd2;

  typedef enum logic [1:0] {
    BP_FIRST = 2'd0,
    BP_LAST  = 2'd1,
    BP_SCAN  = 2'd2
  } bp_sel_t;

  typedef enum logic [1:0] {
    SEG_ZERO = 2'd0,
    SEG_LAST = 2'd1,
    SEG_SCAN = 2'd2
  } seg_src_t;

  typedef struct packed {
    logic     wr_bp;
    logic     wr_coef;
    logic     start;
    bp_sel_t  bp_sel;
    logic     scan_adv;
    logic     prev_load;
    logic     seg_load;
    seg_src_t seg_src;
    logic     acc_load;
    logic     term_adv;
    logic     mul;
    logic     add_step;
    logic     out_load;
  } pcw_cmd_t;

  typedef struct packed {
    logic le_first;
    logic ge_last;
    logic hit;
    logic scan_end;
    logic term_last;
    logic out_free;
  } pcw_sts_t;

endpackage

`default_nettype wire

// ----- sv/pcw_req_if.sv -----
`default_nettype none

interface pcw_req_if;
  import pcw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, index, value, input ready);
  modport sink   (input valid, req_type, index, value, output ready);
endinterface

`default_nettype wire

// ----- sv/pcw_rsp_if.sv -----
`default_nettype none

interface pcw_rsp_if;
  import pcw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_value;
  logic [SEG_O_W-1:0]       segment;
  logic                     overflow;

  modport source (output valid, y_value, segment, overflow, input ready);
  modport sink   (input valid, y_value, segment, overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/pcw_ram.sv -----
`default_nettype none

module pcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/pcw_ctrl.sv -----
`default_nettype none

module pcw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [pcw_pkg::TYPE_W-1:0] req_type,
  output logic                           req_ready,
  input  wire pcw_pkg::pcw_sts_t         sts,
  output pcw_pkg::pcw_cmd_t              cmd
);
  import pcw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD0  = 10'b0000000010,
    S_RDL  = 10'b0000000100,
    S_CHKL = 10'b0000001000,
    S_SCAN = 10'b0000010000,
    S_CA   = 10'b0000100000,
    S_CB   = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_ADD  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_type)
            REQ_BP:   cmd.wr_bp = 1'b1;
            REQ_COEF: cmd.wr_coef = 1'b1;
            REQ_EVAL: begin
              cmd.start  = 1'b1;
              state_next = S_RD0;
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        cmd.bp_sel = BP_FIRST;
        state_next = S_RDL;
      end
      S_RDL: begin
        // first breakpoint is on the read port, fetch the last one
        cmd.bp_sel = BP_LAST;
        if (sts.le_first) begin
          cmd.seg_load = 1'b1;
          cmd.seg_src  = SEG_ZERO;
          state_next   = S_CA;
        end else begin
          cmd.prev_load = 1'b1;
          state_next    = S_CHKL;
        end
      end
      S_CHKL: begin
        if (sts.ge_last) begin
          cmd.seg_load = 1'b1;
          cmd.seg_src  = SEG_LAST;
          state_next   = S_CA;
        end else begin
          cmd.bp_sel   = BP_SCAN;
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.seg_load = 1'b1;
          cmd.seg_src  = SEG_SCAN;
          state_next   = S_CA;
        end else if (sts.scan_end) begin
          // unsorted breakpoints: fall back to the last segment
          cmd.seg_load = 1'b1;
          cmd.seg_src  = SEG_LAST;
          state_next   = S_CA;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.bp_sel    = BP_SCAN;
          cmd.scan_adv  = 1'b1;
        end
      end
      S_CA: begin
        state_next = S_CB;
      end
      S_CB: begin
        cmd.acc_load = 1'b1;
        cmd.term_adv = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        cmd.term_adv = 1'b1;
        state_next   = sts.term_last ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_last_term_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) && sts.term_last |=> (state == S_DONE))
    else $error("constant term added but result not pending");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_bp, cmd.wr_coef, cmd.start}))
    else $error("more than one request action in a cycle");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");
`endif

endmodule

`default_nettype wire

// ----- sv/pcw_dp.sv -----
`default_nettype none

module pcw_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pcw_pkg::pcw_cmd_t                cmd,
  output pcw_pkg::pcw_sts_t                     sts,
  input  wire logic [pcw_pkg::NP_W-1:0]         num_points,
  input  wire logic [pcw_pkg::IDX_W-1:0]        req_index,
  input  wire logic signed [pcw_pkg::DATA_W-1:0] req_value,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic signed [pcw_pkg::DATA_W-1:0]     rsp_y_value,
  output logic [pcw_pkg::SEG_O_W-1:0]           rsp_segment,
  output logic                                  rsp_overflow
);
  import pcw_pkg::*;

  localparam int COEF_DEPTH = 4 * (BP_DEPTH - 1);
  localparam int BP_AW      = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int NW         = $clog2(BP_DEPTH + 1);
  localparam int SEG_W      = (BP_DEPTH > 2) ? $clog2(BP_DEPTH - 1) : 1;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int Q_W        = PROD_W - FRAC_W;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] x, prev, acc;
  logic signed [PROD_W-1:0] prod;
  logic [NW-1:0]            scan;
  logic [SEG_W-1:0]         seg;
  logic [1:0]               term;
  logic                     ovf;

  logic [31:0]              np_ext;
  logic [NW-1:0]            n_eff, n_m1, n_m2;
  logic [BP_AW-1:0]         bp_raddr;
  logic [DATA_W-1:0]        bp_rdata_u, coef_rdata_u;
  logic signed [DATA_W-1:0] bp_rdata, coef_rdata;
  logic                     bp_we, coef_we;

  logic signed [Q_W-1:0]    q;
  logic                     q_ovf, s_ovf;
  logic signed [DATA_W-1:0] q_sat, acc_step;
  logic signed [DATA_W:0]   sum;

  // clamp the configured point count to the supported range
  always_comb begin
    np_ext = 32'(num_points);
    if (np_ext < 32'd2) begin
      n_eff = NW'(2);
    end else if (np_ext > 32'(BP_DEPTH)) begin
      n_eff = NW'(BP_DEPTH);
    end else begin
      n_eff = NW'(np_ext);
    end
    n_m1 = n_eff - NW'(1);
    n_m2 = n_eff - NW'(2);
  end

  assign bp_we   = cmd.wr_bp && (32'(req_index) < 32'(BP_DEPTH));
  assign coef_we = cmd.wr_coef && (32'(req_index) < 32'(COEF_DEPTH));

  always_comb begin
    case (cmd.bp_sel)
      BP_FIRST: bp_raddr = '0;
      BP_LAST:  bp_raddr = BP_AW'(n_m1);
      BP_SCAN:  bp_raddr = BP_AW'(scan);
      default:  bp_raddr = '0;
    endcase
  end

  pcw_ram #(.WIDTH(DATA_W), .DEPTH(BP_DEPTH)) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (BP_AW'(req_index)),
    .wdata (req_value),
    .raddr (bp_raddr),
    .rdata (bp_rdata_u)
  );

  pcw_ram #(.WIDTH(DATA_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (COEF_AW'(req_index)),
    .wdata (req_value),
    .raddr (COEF_AW'({seg, term})),
    .rdata (coef_rdata_u)
  );

  assign bp_rdata   = $signed(bp_rdata_u);
  assign coef_rdata = $signed(coef_rdata_u);

  // drop the fraction (floor), saturate, add the coefficient, saturate again
  always_comb begin
    q     = prod[PROD_W-1:FRAC_W];
    q_ovf = (q[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){1'b0}})
         && (q[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){1'b1}});
    if (q_ovf) begin
      q_sat = q[Q_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      q_sat = q[DATA_W-1:0];
    end
    sum   = {q_sat[DATA_W-1], q_sat} + {coef_rdata[DATA_W-1], coef_rdata};
    s_ovf = (sum[DATA_W] != sum[DATA_W-1]);
    if (s_ovf) begin
      acc_step = sum[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      acc_step = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x    <= req_value;
      scan <= NW'(1);
      term <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.scan_adv) begin
        scan <= scan + NW'(1);
      end
      if (cmd.term_adv) begin
        term <= term + 2'd1;
      end
      if (cmd.add_step) begin
        ovf <= ovf | q_ovf | s_ovf;
      end
    end
    if (cmd.prev_load) begin
      prev <= bp_rdata;
    end
    if (cmd.seg_load) begin
      case (cmd.seg_src)
        SEG_ZERO: seg <= '0;
        SEG_LAST: seg <= SEG_W'(n_m2);
        SEG_SCAN: seg <= SEG_W'(scan - NW'(2));
        default:  seg <= '0;
      endcase
    end
    if (cmd.acc_load) begin
      acc <= coef_rdata;
    end else if (cmd.add_step) begin
      acc <= acc_step;
    end
    if (cmd.mul) begin
      prod <= acc * x;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_y_value  <= acc;
      rsp_segment  <= SEG_O_W'(seg);
      rsp_overflow <= ovf;
    end
  end

  always_comb begin
    sts.le_first  = (x <= bp_rdata);
    sts.ge_last   = (x >= bp_rdata);
    sts.hit       = (x >= prev) && (x <= bp_rdata);
    sts.scan_end  = (scan == n_eff);
    sts.term_last = (term == 2'd3);
    sts.out_free  = !rsp_valid || rsp_ready;
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_adv |-> (32'(scan) < 32'(n_eff)))
    else $error("breakpoint scan ran past the last point");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_load |=> (32'(seg) <= 32'(n_m2)))
    else $error("segment index beyond the last segment");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable({rsp_y_value, rsp_segment, rsp_overflow}))
    else $error("result changed while waiting");
`endif

endmodule

`default_nettype wire

// ----- sv/piecewise_cubic_evaluator.sv -----
`default_nettype none

// Channel   Dir  Payload                          Transfer
// req       in   req_type, index, value           valid & ready
// rsp       out  y_value, segment, overflow       valid & ready
// apb       in   num_points at paddr 0            psel & penable & pwrite
//
// Breakpoint and coefficient writes are taken in the idle state, which they do not leave.
// An evaluation runs the breakpoint scan, one read a cycle from the breakpoint RAM,
// then three multiply/add steps.
// Reset clears the controller, num_points (to 2) and the result valid;
// both RAMs hold garbage until written.
// A waiting result does not block writes; an evaluation holds at its end
// until the result register frees.

module piecewise_cubic_evaluator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pcw_req_if.sink                          req,
  pcw_rsp_if.source                        rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcw_pkg::APB_AW-1:0]  paddr,
  input  wire logic [pcw_pkg::APB_DW-1:0]  pwdata,
  output logic      [pcw_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import pcw_pkg::*;

  logic [NP_W-1:0] num_points;
  logic            reg_sel;
  pcw_cmd_t        cmd;
  pcw_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_NUM_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NUM_POINTS_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      num_points <= pwdata[NP_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(num_points) : '0;

  pcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .num_points   (num_points),
    .req_index    (req.index),
    .req_value    (req.value),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_y_value  (rsp.y_value),
    .rsp_segment  (rsp.segment),
    .rsp_overflow (rsp.overflow)
  );

endmodule

`default_nettype wire

// ----- tb/tb_piecewise_cubic_evaluator.sv -----
module tb_piecewise_cubic_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  import pcw_pkg::*;

  localparam int MAX_PTS       = BP_DEPTH;
  localparam int COEF_DEPTH    = 4 * (MAX_PTS - 1);
  localparam int ITEM_TARGET   = 1300;
  localparam int CALM_ITEMS    = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int STUCK_LIMIT   = 2000;

  localparam logic [TYPE_W-1:0] REQ_RSVD = 2'd3;
  localparam logic [APB_AW-1:0] NP_ADDR       = APB_AW'(4 * REG_NUM_POINTS);
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(4 * (REG_NUM_POINTS + 1));

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic [SEG_O_W-1:0]       segment;
    logic                     overflow;
  } spline_point_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic              typed;
    spline_point_t     want;
  } vector_t;

  localparam spline_point_t NO_POINT  = '0;
  localparam spline_point_t FIVE      = '{32'sh00050000, 5'd0, 1'b0};
  localparam spline_point_t SAT_HIGH  = '{32'sh7FFFFFFF, 5'd0, 1'b1};
  localparam int NUM_VECTORS = 29;

  // Start from the reset point count of two: one segment, then corner values.
  vector_t vectors [NUM_VECTORS] = '{
    '{REQ_BP,   7'd0,   32'hFFFF0000, 1'b0, NO_POINT},
    '{REQ_BP,   7'd1,   32'h00010000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd0,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd1,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd2,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd3,   32'h00050000, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h80000000, 1'b1, FIVE},
    '{REQ_EVAL, 7'd127, 32'h7FFFFFFF, 1'b1, FIVE},
    '{REQ_EVAL, 7'd0,   32'hFFFF0000, 1'b1, FIVE},
    '{REQ_EVAL, 7'd0,   32'h00000000, 1'b1, FIVE},
    '{REQ_EVAL, 7'd0,   32'h00010000, 1'b1, FIVE},
    '{REQ_COEF, 7'd2,   32'h7FFFFFFF, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd3,   32'h7FFFFFFF, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h00010000, 1'b1, SAT_HIGH},
    '{REQ_COEF, 7'd0,   32'h80000000, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h80000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd3,   32'h80000000, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd0,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd2,   32'hFFFFFFFF, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd3,   32'h00000000, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h00008000, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'hFFFF8000, 1'b0, NO_POINT},
    '{REQ_BP,   7'd32,  32'h12345678, 1'b0, NO_POINT},
    '{REQ_BP,   7'd127, 32'hEDCBA987, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd124, 32'h5A5A5A5A, 1'b0, NO_POINT},
    '{REQ_COEF, 7'd127, 32'hA5A5A5A5, 1'b0, NO_POINT},
    '{REQ_RSVD, 7'd5,   32'hFFFFFFFF, 1'b0, NO_POINT},
    '{REQ_EVAL, 7'd0,   32'h00004000, 1'b0, NO_POINT}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  pcw_req_if req_ch();
  pcw_rsp_if rsp_ch();

  piecewise_cubic_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5ns clk = ~clk;

  // Shadow of the block state
  logic signed [DATA_W-1:0] knot [MAX_PTS];
  logic signed [DATA_W-1:0] coef [COEF_DEPTH];
  logic [NP_W-1:0] num_pts = NUM_POINTS_RST;

  spline_point_t pending_points [$];
  int  items_done = 0;
  int  checked = 0;
  int  settings_used = 0;
  int  errors = 0;
  bit  burst = 1'b0;
  bit  calm = 1'b0;
  bit  hold_results = 1'b0;

  function automatic int active_points();
    if (num_pts < 2) return 2;
    if (num_pts > MAX_PTS) return MAX_PTS;
    return int'(num_pts);
  endfunction

  function automatic logic signed [DATA_W-1:0] saturate(input logic signed [63:0] v,
                                                         inout bit ovf);
    if (v > 64'sh7FFFFFFF) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] horner_step(
      input logic signed [DATA_W-1:0] acc, input logic signed [DATA_W-1:0] x,
      input logic signed [DATA_W-1:0] c, inout bit ovf);
    logic signed [63:0] wide_acc, wide_x, prod, sum;
    logic signed [DATA_W-1:0] q;
    wide_acc = acc;
    wide_x = x;
    // arithmetic shift floors toward minus infinity
    prod = (wide_acc * wide_x) >>> FRAC_W;
    q = saturate(prod, ovf);
    sum = q;
    sum = sum + c;
    return saturate(sum, ovf);
  endfunction

  function automatic spline_point_t eval_spline(input logic signed [DATA_W-1:0] x);
    int n, k, i;
    bit found, ovf;
    logic signed [DATA_W-1:0] acc;
    spline_point_t r;
    n = active_points();
    found = 1'b0;
    ovf = 1'b0;
    if (x <= knot[0]) begin
      k = 0;
    end else if (x >= knot[n-1]) begin
      k = n - 2;
    end else begin
      // unsorted breakpoints may match nothing: keep the last segment
      k = n - 2;
      for (i = 0; i + 1 < n; i++)
        if (!found && x >= knot[i] && x <= knot[i+1]) begin
          k = i;
          found = 1'b1;
        end
    end
    acc = coef[4*k];
    acc = horner_step(acc, x, coef[4*k+1], ovf);
    acc = horner_step(acc, x, coef[4*k+2], ovf);
    acc = horner_step(acc, x, coef[4*k+3], ovf);
    r.y_value = acc;
    r.segment = k[SEG_O_W-1:0];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_x(input int n);
    logic signed [63:0] lo, hi, v;
    int k;
    k = $urandom_range(0, n - 1);
    lo = knot[0];
    hi = knot[n-1];
    if (lo > hi) begin
      v = lo;
      lo = hi;
      hi = v;
    end
    case ($urandom_range(0, 9))
      0: return knot[k];
      1: return knot[k] + 1;
      2: return knot[k] - 1;
      3: return $urandom;
      4: return ($urandom_range(0, 1) == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      5: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
      default: begin
        v = lo - 65536 + 64'({$urandom, $urandom} % 64'(hi - lo + 131072));
        if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return v[DATA_W-1:0];
      end
    endcase
  endfunction

  task automatic issue(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] idx,
                       input logic [DATA_W-1:0] val, input bit typed = 1'b0,
                       input spline_point_t want = '0);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.index <= idx;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    case (kind)
      REQ_BP: if (idx < MAX_PTS) begin
        knot[idx] = val;
        items_done++;
      end
      REQ_COEF: if (idx < COEF_DEPTH) begin
        coef[idx] = val;
        items_done++;
      end
      REQ_EVAL: begin
        pending_points.push_back(typed ? want : eval_spline(val));
        items_done++;
      end
      default: ;
    endcase
    if (!calm && !burst && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Write one register, then read the point count back through the same select.
  task automatic program_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == NP_ADDR) num_pts = data[NP_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= NP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(num_pts)) begin
      $error("num_points: expected %0d, got %0d", num_pts, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    // an evaluation may still be in flight behind writes
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_table(input int n);
    logic signed [DATA_W-1:0] pts [MAX_PTS];
    int mode, i;
    bit wide;
    mode = $urandom_range(0, 4);
    wide = ($urandom_range(0, 3) == 0);
    if (mode == 2) pts[0] = -(1 << 30) + int'($urandom_range(0, 1 << 20));
    else if (mode == 3) pts[0] = $urandom;
    else pts[0] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
    for (i = 1; i < n; i++)
      case (mode)
        2: pts[i] = pts[i-1] + int'($urandom_range(0, 1 << 25));
        3: pts[i] = $urandom;
        default: pts[i] = pts[i-1] + int'($urandom_range(1, 1 << 15));
      endcase
    if (mode == 4) begin
      pts[0] = 32'sh80000000;
      pts[n-1] = 32'sh7FFFFFFF;
    end
    for (i = 0; i < n; i++) issue(REQ_BP, IDX_W'(i), pts[i]);
    for (i = 0; i < 4 * (n - 1); i++)
      issue(REQ_COEF, IDX_W'(i), (wide || $urandom_range(0, 15) == 0) ?
            $urandom : int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endtask

  task automatic check_point();
    spline_point_t want;
    if (pending_points.size() == 0) begin
      $error("result with none expected: y_value %0d, segment %0d, overflow %0d",
             rsp_ch.y_value, rsp_ch.segment, rsp_ch.overflow);
      errors++;
      return;
    end
    want = pending_points.pop_front();
    checked++;
    if (rsp_ch.y_value !== want.y_value) begin
      $error("y_value: expected %0d, got %0d", want.y_value, rsp_ch.y_value);
      errors++;
    end
    if (rsp_ch.segment !== want.segment) begin
      $error("segment: expected %0d, got %0d", want.segment, rsp_ch.segment);
      errors++;
    end
    if (rsp_ch.overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, rsp_ch.overflow);
      errors++;
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) check_point();
      if (hold_results) begin
        hold_results = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (calm) begin
        stall_left = 0;
      end else if (stall_left == 0 && quiet_left > 0) begin
        quiet_left--;
      end else if (stall_left == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2: stall_left = $urandom_range(1, 16);
          3: quiet_left = $urandom_range(20, 100);
          default: ;
        endcase
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable && pready))
        stuck = 0;
      else
        stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("No transaction for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, pending_points.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int point_counts [8] = '{32, 3, 0, 1, 63, 2, 33, 17};
    logic [NP_W-1:0] np;
    logic [TYPE_W-1:0] kind;
    int phase, n, evals, i, j;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_BP;
    req_ch.index <= '0;
    req_ch.value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // unmapped write must leave the reset point count untouched
    program_reg(UNMAPPED_ADDR, 32'hFFFFFFFF);
    for (i = 0; i < NUM_VECTORS; i++)
      issue(vectors[i].kind, vectors[i].idx, vectors[i].val, vectors[i].typed,
            vectors[i].want);

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      drain();
      np = (phase < 8) ? NP_W'(point_counts[phase]) : NP_W'($urandom_range(0, 63));
      program_reg(NP_ADDR, ($urandom & ~32'h3F) | APB_DW'(np));
      settings_used++;
      n = active_points();
      load_table(n);
      if (phase == 1) begin
        burst = 1'b1;
        hold_results = 1'b1;
      end
      evals = $urandom_range(25, 70);
      for (j = 0; j < evals && items_done < ITEM_TARGET; j++) begin
        if (items_done >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 2))
            0: kind = REQ_BP;
            1: kind = REQ_COEF;
            default: kind = REQ_RSVD;
          endcase
          issue(kind, IDX_W'($urandom_range(0, 127)), $urandom);
        end else begin
          issue(REQ_EVAL, IDX_W'($urandom), pick_x(n));
        end
      end
      burst = 1'b0;
      phase++;
    end

    req_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run: %0d transactions accepted, %0d evaluations checked, %0d point-count settings",
             items_done, checked, settings_used);
    $display("Stalls on both channels, one long result hold-off, saturating and unsorted tables");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
